/* rtl/jttv_pkg.sv */
// ----------------------------------------------------------------------------
// jttv_pkg
// Shared types and constants of the JSON token tree validator.
// ----------------------------------------------------------------------------
`default_nettype none

package jttv_pkg;

   // Stack capacity in frames and width of a frame's child counter.
   localparam int MAX_DEPTH  = 32;
   localparam int COUNT_BITS = 16;

   localparam int ADDR_BITS  = $clog2(MAX_DEPTH);
   localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

   // Token type codes as they arrive on the input.
   typedef enum logic [2:0] {
      TY_UNDEF  = 3'd0,
      TY_OBJECT = 3'd1,
      TY_ARRAY  = 3'd2,
      TY_STRING = 3'd3,
      TY_PRIM   = 3'd4
   } token_kind_type;

   // Kind of an open frame on the stack.
   typedef enum logic [1:0] {
      KIND_ARRAY  = 2'd0,
      KIND_OBJECT = 2'd1,
      KIND_KEY    = 2'd2
   } frame_kind_type;

   // Error codes, the first one of a sequence is kept.
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_TYPE   = 3'd1,
      ERR_SCALAR     = 3'd2,
      ERR_BAD_UTF8   = 3'd3,
      ERR_BAD_KEY    = 3'd4,
      ERR_INCOMPLETE = 3'd5,
      ERR_OVERFLOW   = 3'd6
   } err_type;

   typedef struct packed {
      frame_kind_type          kind;
      logic [COUNT_BITS-1:0]   remaining;
   } frame_type;

   typedef struct packed {
      logic                    en;
      logic [ADDR_BITS-1:0]    addr;
      frame_type               frame;
   } ram_wr_type;

   typedef struct packed {
      logic                    done;
      logic                    ok;
      err_type                 err;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/jttv_frame_ram.sv */
// ----------------------------------------------------------------------------
// jttv_frame_ram
// Frame store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jttv_frame_ram
   import jttv_pkg::*;
(
   input  wire logic                 clock,
   input  wire ram_wr_type           wr,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      frame_type            rd_frame
);

   frame_type mem [MAX_DEPTH];
   frame_type rd_frame_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.frame;
      end
   end

   always_ff @(posedge clock) begin
      rd_frame_ff <= mem[rd_addr];
   end

   assign rd_frame = rd_frame_ff;

endmodule

`default_nettype wire

/* rtl/jttv_core.sv */
// ----------------------------------------------------------------------------
// jttv_core
// Token checker and stack control. The top frame lives in registers; frames
// below it live in the frame store, and the one just below the top is always
// prefetched so that a pop never waits for a memory read.
// ----------------------------------------------------------------------------
`default_nettype none

module jttv_core
   import jttv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_accept,
   input  wire logic [2:0]           tok_type,
   input  wire logic [15:0]          tok_count,
   input  wire logic                 tok_utf8_ok,
   input  wire logic                 tok_last,
   output      ram_wr_type           ram_wr,
   output      logic [ADDR_BITS-1:0] ram_rd_addr,
   input  wire frame_type            ram_rd_frame,
   output      rsp_type              rsp
);

   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   err_type               err_ff, err_in;
   frame_type             top_ff, top_in;
   logic                  fwd_ff, fwd_in;
   frame_type             fwd_frame_ff, fwd_frame_in;

   logic [COUNT_BITS-1:0] cnt;
   frame_type             below;
   frame_type             dec_frame;
   logic                  have_top;
   logic                  want_key;
   logic                  pops;
   logic                  push;
   frame_type             push_frame;
   err_type               chk_err;
   logic [DEPTH_BITS-1:0] depth_after_pop;
   logic [DEPTH_BITS-1:0] next_depth;
   logic                  overflow;
   err_type               new_err;
   err_type               out_err;

   assign cnt      = COUNT_BITS'(tok_count);
   assign below    = fwd_ff ? fwd_frame_ff : ram_rd_frame;
   assign have_top = (depth_ff != '0);
   assign want_key = have_top && (top_ff.kind == KIND_OBJECT);

   assign dec_frame.kind      = top_ff.kind;
   assign dec_frame.remaining = top_ff.remaining - COUNT_BITS'(1);
   assign pops                = have_top && (dec_frame.remaining == '0);

   // Token shape check against the current top frame.
   always_comb begin
      chk_err    = ERR_NONE;
      push       = 1'b0;
      push_frame = '{kind: KIND_ARRAY, remaining: cnt};
      if (want_key) begin
         if (tok_type != TY_STRING || cnt != COUNT_BITS'(1) || !tok_utf8_ok) begin
            chk_err = ERR_BAD_KEY;
         end else begin
            push       = 1'b1;
            push_frame = '{kind: KIND_KEY, remaining: COUNT_BITS'(1)};
         end
      end else if (tok_type > TY_PRIM) begin
         chk_err = ERR_BAD_TYPE;
      end else if (tok_type == TY_STRING && !tok_utf8_ok) begin
         chk_err = ERR_BAD_UTF8;
      end else if ((tok_type == TY_UNDEF || tok_type == TY_STRING ||
                    tok_type == TY_PRIM) && cnt != '0) begin
         chk_err = ERR_SCALAR;
      end else if ((tok_type == TY_OBJECT || tok_type == TY_ARRAY) && cnt != '0) begin
         push       = 1'b1;
         push_frame = '{kind: (tok_type == TY_OBJECT) ? KIND_OBJECT : KIND_ARRAY,
                        remaining: cnt};
      end
   end

   assign depth_after_pop = depth_ff - DEPTH_BITS'(pops);
   assign next_depth      = depth_after_pop + DEPTH_BITS'(push);
   assign overflow        = push && (depth_after_pop >= DEPTH_BITS'(MAX_DEPTH));

   always_comb begin
      if (err_ff != ERR_NONE) begin
         new_err = err_ff;
      end else if (chk_err != ERR_NONE) begin
         new_err = chk_err;
      end else if (overflow) begin
         new_err = ERR_OVERFLOW;
      end else begin
         new_err = ERR_NONE;
      end
   end

   assign out_err  = (tok_last && new_err == ERR_NONE && next_depth != '0) ?
                     ERR_INCOMPLETE : new_err;
   assign rsp.done = tok_last;
   assign rsp.ok   = (out_err == ERR_NONE);
   assign rsp.err  = out_err;

   // Stack update and frame store write.
   always_comb begin
      depth_in     = depth_ff;
      err_in       = err_ff;
      top_in       = top_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = ADDR_BITS'(depth_ff - DEPTH_BITS'(1));
      ram_wr.frame = dec_frame;
      if (tok_accept) begin
         if (tok_last) begin
            depth_in = '0;
            err_in   = ERR_NONE;
         end else if (err_ff == ERR_NONE) begin
            if (new_err != ERR_NONE) begin
               err_in = new_err;
            end else begin
               depth_in = next_depth;
               if (push) begin
                  top_in = push_frame;
               end else if (pops) begin
                  top_in = below;
               end else begin
                  top_in = dec_frame;
               end
               // The old top is pushed under a new frame: spill it.
               ram_wr.en = push && have_top && !pops;
            end
         end
      end
   end

   // Always prefetch the frame just below the next top.
   assign ram_rd_addr  = ADDR_BITS'(depth_in - DEPTH_BITS'(2));
   assign fwd_in       = ram_wr.en && (ram_wr.addr == ram_rd_addr);
   assign fwd_frame_in = ram_wr.frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= ERR_NONE;
         fwd_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      fwd_frame_ff <= fwd_frame_in;
   end

endmodule

`default_nettype wire

/* rtl/jttv_out_skid.sv */
// ----------------------------------------------------------------------------
// jttv_out_skid
// Two-entry output buffer; the input side is ready whenever the skid slot
// is empty, so the upstream ready never depends on the downstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jttv_out_skid
   import jttv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output      logic    in_ready,
   input  wire rsp_type in_data,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign take      = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid && in_ready) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

/* rtl/json_token_tree_validator.sv */
// ----------------------------------------------------------------------------
// json_token_tree_validator
// Checks a pre-order stream of JSON tokens for a well-formed tree shape and
// reports, for every token word, whether the sequence is still valid.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload
//   req_*     in          one token word: type, child count, UTF-8 flag, last
//   rsp_*     out         one verdict word per token: done, valid, error code
//
// The block takes one token word per cycle while req_tready is high and
// registers its verdict word in the output buffer. The per-token work is a
// single read-modify-write of the top stack frame; the top frame is held in
// registers and the frame below it is prefetched from the frame store every
// cycle, so a pop never waits for a memory read. The frame store needs no
// clearing after reset. Reset is synchronous and active high. A stalled
// result waits in a two-entry output buffer; req_tready drops only when both
// entries are full.
// Errors are sticky: after the first error, tokens are ignored until the
// word marked last, which reports the final verdict and returns the stack
// and the error to their empty state for the next sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module json_token_tree_validator
   import jttv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [15:0] child_count, [16] text_utf8_ok, [23:17] zero
   input  wire logic [23:0] req_tdata,
   // [2:0] token_type
   input  wire logic [2:0]  req_tuser,
   // last_token
   input  wire logic        req_tlast,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] still_valid, [3:1] error_kind, [7:4] zero
   output      logic [7:0]  rsp_tdata,
   // sequence_done
   output      logic        rsp_tlast
);

   logic                 tok_accept;
   ram_wr_type           ram_wr;
   logic [ADDR_BITS-1:0] ram_rd_addr;
   frame_type            ram_rd_frame;
   rsp_type              core_rsp;
   rsp_type              out_rsp;

   // A word is accepted whenever the output buffer has room.
   assign tok_accept = req_tvalid && req_tready;

   jttv_core u_core (
      .clock        (clock),
      .reset        (reset),
      .tok_accept   (tok_accept),
      .tok_type     (req_tuser),
      .tok_count    (req_tdata[15:0]),
      .tok_utf8_ok  (req_tdata[16]),
      .tok_last     (req_tlast),
      .ram_wr       (ram_wr),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_frame (ram_rd_frame),
      .rsp          (core_rsp)
   );

   // Frames below the top of the stack.
   jttv_frame_ram u_frame_ram (
      .clock    (clock),
      .wr       (ram_wr),
      .rd_addr  (ram_rd_addr),
      .rd_frame (ram_rd_frame)
   );

   jttv_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tok_accept),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {4'b0000, out_rsp.err, out_rsp.ok};
   assign rsp_tlast = out_rsp.done;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for json_token_tree_validator: token words go in on the
// req_ stream, every verdict word on the rsp_ stream is compared field by
// field against an in-bench model of the frame stack and the sticky error.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import jttv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Type codes that the block must reject; they have no name in the package.
   localparam logic [2:0] TY_BAD_LO = 3'd5;
   localparam logic [2:0] TY_BAD_MID = 3'd6;
   localparam logic [2:0] TY_BAD_HI = 3'd7;

   // Length of the forced receiver hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 60;

   // One token word as the bench sees it, before it is packed onto the bus.
   typedef struct packed {
      logic [2:0]            ttype;
      logic [COUNT_BITS-1:0] count;
      logic                  utf8;
      logic                  last;
   } token_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] child_count, [16] text_utf8_ok, [23:17] zero
   logic [23:0] req_tdata = '0;
   // [2:0] token_type
   logic [2:0]  req_tuser = '0;
   // last_token
   logic        req_tlast = 1'b0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] still_valid, [3:1] error_kind, [7:4] zero
   logic [7:0]  rsp_tdata;
   // sequence_done
   logic        rsp_tlast;

   json_token_tree_validator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Percent of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Bookkeeping for the checker and the closing summary.
   rsp_type        verdict_queue[$];
   token_word_type token_plan[$];
   int             failures = 0;
   int             tokens_sent = 0;
   int             live_tokens = 0;
   int             verdicts_checked = 0;
   int             final_verdicts[8];

   // A hold-off is asked for by bumping hold_requests; the receiver process
   // notices the change and counts the stall out on its own.
   int hold_requests = 0;

   // ------------------------------------------------------------------------
   // Model of the validator: its own frame stack and sticky first error.
   // Entries at or above nest_depth are never read, so they need no clearing.
   // ------------------------------------------------------------------------
   frame_kind_type        nest_kind[MAX_DEPTH];
   logic [COUNT_BITS-1:0] nest_left[MAX_DEPTH];
   int                    nest_depth = 0;
   err_type               seq_err = ERR_NONE;

   // Checks one token against the top frame and updates the stack. Only an
   // overflow return changes the stack first; the error is sticky anyway.
   function automatic err_type judge_token(logic [2:0] ttype,
                                           logic [COUNT_BITS-1:0] count,
                                           logic utf8);
      logic                  want_key;
      logic                  do_push;
      frame_kind_type        push_kind;
      logic [COUNT_BITS-1:0] push_left;
      want_key = (nest_depth > 0) && (nest_kind[nest_depth-1] == KIND_OBJECT);
      do_push = 1'b0;
      push_kind = KIND_ARRAY;
      push_left = '0;
      if (want_key) begin
         // Inside an object only a well-formed key may appear.
         if (ttype != TY_STRING || count != 1 || !utf8) return ERR_BAD_KEY;
         do_push = 1'b1;
         push_kind = KIND_KEY;
         push_left = 1;
      end else begin
         if (ttype > TY_PRIM) return ERR_BAD_TYPE;
         if (ttype == TY_STRING && !utf8) return ERR_BAD_UTF8;
         if ((ttype == TY_UNDEF || ttype == TY_STRING || ttype == TY_PRIM) &&
             count != 0) return ERR_SCALAR;
         if ((ttype == TY_OBJECT || ttype == TY_ARRAY) && count != 0) begin
            do_push = 1'b1;
            push_kind = (ttype == TY_OBJECT) ? KIND_OBJECT : KIND_ARRAY;
            push_left = count;
         end
      end
      // The child uses up one slot of its parent; a finished parent is popped
      // first, so the new frame can take its place.
      if (nest_depth > 0) begin
         nest_left[nest_depth-1] = nest_left[nest_depth-1] - 1'b1;
         if (nest_left[nest_depth-1] == 0) nest_depth = nest_depth - 1;
      end
      if (do_push) begin
         if (nest_depth >= MAX_DEPTH) return ERR_OVERFLOW;
         nest_kind[nest_depth] = push_kind;
         nest_left[nest_depth] = push_left;
         nest_depth = nest_depth + 1;
      end
      return ERR_NONE;
   endfunction

   // Verdict word for one accepted token; the last token closes the sequence.
   function automatic rsp_type predict_verdict(token_word_type tok);
      rsp_type verdict;
      if (seq_err == ERR_NONE) seq_err = judge_token(tok.ttype, tok.count, tok.utf8);
      if (tok.last && seq_err == ERR_NONE && nest_depth != 0) seq_err = ERR_INCOMPLETE;
      verdict.done = tok.last;
      verdict.ok = (seq_err == ERR_NONE);
      verdict.err = seq_err;
      if (tok.last) begin
         nest_depth = 0;
         seq_err = ERR_NONE;
      end
      return verdict;
   endfunction

   function automatic token_word_type make_token(logic [2:0] ttype,
                                                 logic [COUNT_BITS-1:0] count,
                                                 logic utf8, logic last);
      token_word_type tok;
      tok.ttype = ttype;
      tok.count = count;
      tok.utf8 = utf8;
      tok.last = last;
      return tok;
   endfunction

   // Child counts for noise: half tiny, half anywhere in the 16-bit range so
   // that every count bit is exercised.
   function automatic logic [COUNT_BITS-1:0] random_count();
      if ($urandom_range(1) != 0) return COUNT_BITS'($urandom_range(65535));
      return COUNT_BITS'($urandom_range(2));
   endfunction

   // ------------------------------------------------------------------------
   // Sender side. The valid line is left high after a handshake, so the next
   // call either keeps it up with new data or drops it for an idle cycle.
   // ------------------------------------------------------------------------
   task automatic send_token(input token_word_type tok);
      rsp_type verdict;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= tok.ttype;
      req_tdata <= {7'd0, tok.utf8, tok.count};
      req_tlast <= tok.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // Words swallowed during error recovery do not count as live traffic.
      if (seq_err == ERR_NONE || tok.last) live_tokens++;
      verdict = predict_verdict(tok);
      verdict_queue.push_back(verdict);
      tokens_sent++;
      if (tok.last) final_verdicts[verdict.err]++;
   endtask

   task automatic send_plan();
      foreach (token_plan[i]) send_token(token_plan[i]);
   endtask

   // Sender pauses until every outstanding verdict has come back and the
   // pipeline has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side and result checker.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      int hold_served;
      int hold_left;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Values are sampled as they stood just before the edge, so the order of
   // processes within the time step does not matter.
   always @(posedge clock) begin : check_verdicts
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.done = rsp_tlast;
         seen.ok = rsp_tdata[0];
         seen.err = err_type'(rsp_tdata[3:1]);
         verdicts_checked++;
         if (verdict_queue.size() == 0) begin
            failures++;
            $display("%0t: unexpected verdict word, expected none, %s",
                     $time, $sformatf("got done=%b valid=%b error=%0d",
                                      seen.done, seen.ok, seen.err));
         end else begin
            want = verdict_queue.pop_front();
            if (seen.done !== want.done || seen.ok !== want.ok ||
                seen.err !== want.err) begin
               failures++;
               $display("%0t: verdict mismatch, expected done=%b valid=%b error=%0d,",
                        $time, want.done, want.ok, want.err);
               $display("%0t:    got done=%b valid=%b error=%0d",
                        $time, seen.done, seen.ok, seen.err);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus generators.
   // ------------------------------------------------------------------------

   // Builds one well-formed sequence of top-level datums in pre-order, with a
   // shadow stack to know where keys are due. Hitting max_tokens cuts the tree
   // short, which leaves it open at the last token.
   task automatic plan_tree(input int max_nest, input int nest_pct,
                            input int count_lo, input int count_hi,
                            input int max_tokens);
      frame_kind_type open_kind[$];
      int             open_left[$];
      int             tops;
      token_word_type tok;
      token_plan.delete();
      tops = $urandom_range(3, 1);
      while ((tops > 0 || open_kind.size() > 0) && token_plan.size() < max_tokens) begin
         tok = make_token(TY_UNDEF, 0, 1'($urandom_range(1)), 1'b0);
         if (open_kind.size() == 0) tops--;
         if (open_kind.size() > 0 && open_kind[$] == KIND_OBJECT) begin
            tok.ttype = TY_STRING;
            tok.count = 1;
            tok.utf8 = 1'b1;
         end else if (open_kind.size() < max_nest && $urandom_range(99) < nest_pct) begin
            tok.ttype = ($urandom_range(1) != 0) ? TY_OBJECT : TY_ARRAY;
            tok.count = COUNT_BITS'($urandom_range(count_hi, count_lo));
         end else begin
            case ($urandom_range(2))
               0: tok.ttype = TY_UNDEF;
               1: begin
                  tok.ttype = TY_STRING;
                  tok.utf8 = 1'b1;
               end
               default: tok.ttype = TY_PRIM;
            endcase
         end
         if (open_kind.size() > 0) begin
            open_left[$] = open_left[$] - 1;
            if (open_left[$] == 0) begin
               void'(open_kind.pop_back());
               void'(open_left.pop_back());
            end
         end
         if (tok.count != 0) begin
            if (tok.ttype == TY_STRING) open_kind.push_back(KIND_KEY);
            else if (tok.ttype == TY_OBJECT) open_kind.push_back(KIND_OBJECT);
            else open_kind.push_back(KIND_ARRAY);
            open_left.push_back(tok.count);
         end
         token_plan.push_back(tok);
      end
   endtask

   // Damages a planned sequence: one word gets random content, or the tail
   // is cut off.
   task automatic spoil_plan();
      int idx;
      int keep;
      if ($urandom_range(1) != 0) begin
         idx = $urandom_range(token_plan.size() - 1);
         token_plan[idx].ttype = 3'($urandom_range(7));
         token_plan[idx].count = random_count();
         token_plan[idx].utf8 = 1'($urandom_range(1));
      end else begin
         keep = $urandom_range(token_plan.size(), 1);
         while (token_plan.size() > keep) void'(token_plan.pop_back());
      end
   endtask

   // Words with fully random fields; the last flag also shows up mid-run.
   task automatic plan_noise();
      int n;
      n = $urandom_range(8, 1);
      token_plan.delete();
      for (int i = 0; i < n; i++)
         token_plan.push_back(make_token(3'($urandom_range(7)), random_count(),
                                         1'($urandom_range(1)),
                                         ($urandom_range(5) == 0) || (i == n - 1)));
   endtask

   // Mostly well-formed trees with random content, with some deep chains that
   // run into the depth limit, some damaged trees and some noise.
   task automatic random_phase(input int idle_pct, input int stall_pct, input int budget);
      int goal;
      int pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal = live_tokens + budget;
      while (live_tokens < goal) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            plan_tree(MAX_DEPTH + 8, 95, 2, 2, 80);
         end else if (pick < 85) begin
            plan_tree(6, 40, 0, 4, 40);
            if ($urandom_range(99) < 25) spoil_plan();
         end else begin
            plan_noise();
         end
         token_plan[$].last = 1'b1;
         send_plan();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // With an empty stack any datum is fine, so several may share a sequence.
   task automatic test_top_level();
      send_token(make_token(TY_UNDEF, 0, 1'b0, 1'b0));
      send_token(make_token(TY_STRING, 0, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b0, 1'b0));
      send_token(make_token(TY_OBJECT, 0, 1'b1, 1'b0));
      send_token(make_token(TY_ARRAY, 0, 1'b0, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b1, 1'b1));
   endtask

   // An object holding an array and an empty object, closed properly.
   task automatic test_nesting();
      send_token(make_token(TY_OBJECT, 2, 1'b0, 1'b0));
      send_token(make_token(TY_STRING, 1, 1'b1, 1'b0));
      send_token(make_token(TY_ARRAY, 2, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b0, 1'b0));
      send_token(make_token(TY_STRING, 0, 1'b1, 1'b0));
      send_token(make_token(TY_STRING, 1, 1'b1, 1'b0));
      send_token(make_token(TY_OBJECT, 0, 1'b0, 1'b1));
   endtask

   // One short sequence per error code except overflow, plus a check that errors stick.
   task automatic test_error_codes();
      send_token(make_token(TY_BAD_LO, 0, 1'b1, 1'b1));
      send_token(make_token(TY_ARRAY, 1, 1'b1, 1'b0));
      send_token(make_token(TY_BAD_HI, 16'hFFFF, 1'b0, 1'b1));
      // Keys: a bad type, a wrong child count, bad text.
      send_token(make_token(TY_OBJECT, 1, 1'b1, 1'b0));
      send_token(make_token(TY_BAD_MID, 1, 1'b1, 1'b1));
      send_token(make_token(TY_OBJECT, 1, 1'b1, 1'b0));
      send_token(make_token(TY_STRING, 16'hFFFF, 1'b1, 1'b1));
      send_token(make_token(TY_OBJECT, 16'hFFFF, 1'b1, 1'b0));
      send_token(make_token(TY_STRING, 1, 1'b0, 1'b1));
      // Scalars with children; a string with bad text and children is a
      // text error, not a scalar error.
      send_token(make_token(TY_PRIM, 16'hFFFF, 1'b1, 1'b1));
      send_token(make_token(TY_UNDEF, 1, 1'b0, 1'b1));
      send_token(make_token(TY_STRING, 2, 1'b0, 1'b1));
      // A container still open at the last word.
      send_token(make_token(TY_ARRAY, 16'hFFFF, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b1, 1'b1));
      // The first error holds while later words would be fine or bad too.
      send_token(make_token(TY_PRIM, 1, 1'b1, 1'b0));
      send_token(make_token(TY_OBJECT, 1, 1'b1, 1'b0));
      send_token(make_token(TY_BAD_HI, 0, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b1, 1'b1));
   endtask

   // Arrays with two children nest one level per word. A full stack is fine
   // (the sequence then ends open); one more level overflows.
   task automatic test_depth_limit();
      for (int i = 0; i < MAX_DEPTH; i++)
         send_token(make_token(TY_ARRAY, 2, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b1, 1'b1));
      for (int i = 0; i <= MAX_DEPTH; i++)
         send_token(make_token(TY_ARRAY, 2, 1'b1, 1'b0));
      send_token(make_token(TY_PRIM, 0, 1'b1, 1'b1));
   endtask

   // The receiver holds off while the sender keeps offering words, so the
   // output buffer fills and req_tready has to drop.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_requests++;
      plan_tree(4, 50, 1, 3, 24);
      token_plan[$].last = 1'b1;
      send_plan();
      plan_noise();
      send_plan();
      drain();
   endtask

   // Three idle profiles: receiver lazy, then sender lazy, then no idling.
   task automatic test_random_traffic();
      random_phase(21, 62, 180);
      drain();
      random_phase(62, 21, 180);
      drain();
      random_phase(0, 0, 180);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : run_tests
      int wait_cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 21;
      rsp_stall_pct = 62;
      test_top_level();
      test_nesting();
      test_error_codes();
      test_depth_limit();
      drain();
      test_backpressure();
      test_random_traffic();

      // Wait for the tail of the traffic, but not forever.
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (verdict_queue.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (verdict_queue.size() != 0) begin
         failures += verdict_queue.size();
         $display("%0t: %0d verdict words never arrived", $time, verdict_queue.size());
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d token words (%0d outside error recovery), %s",
               tokens_sent, live_tokens,
               $sformatf("checked %0d verdict words.", verdicts_checked));
      $display("Sequences by verdict: valid %0d, bad type %0d, scalar %0d, %s",
               final_verdicts[ERR_NONE], final_verdicts[ERR_BAD_TYPE],
               final_verdicts[ERR_SCALAR],
               $sformatf("bad UTF-8 %0d, bad key %0d, open %0d, overflow %0d.",
                         final_verdicts[ERR_BAD_UTF8], final_verdicts[ERR_BAD_KEY],
                         final_verdicts[ERR_INCOMPLETE], final_verdicts[ERR_OVERFLOW]));
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: the slowest correct run is far below this.
   initial begin : watchdog
      #2_000_000;
      $display("%0t: timeout with %0d verdict words outstanding", $time, verdict_queue.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
